@@ rtl/top_k_index_select_defines.svh @@
// ---------------------------------------------------------------------------
// top_k_index_select_defines.svh
// Assertion macros shared by the top-k index select block.
// ---------------------------------------------------------------------------
`ifndef TOP_K_INDEX_SELECT_DEFINES_SVH
`define TOP_K_INDEX_SELECT_DEFINES_SVH

// same-cycle implication, quiet while reset is asserted
`define TKIS_ASSERT_IMPLY(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication, quiet while reset is asserted
`define TKIS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

@@ rtl/tkis_pkg.sv @@
// ---------------------------------------------------------------------------
// tkis_pkg
// Shared widths and controller/datapath handshake types.
// ---------------------------------------------------------------------------
package tkis_pkg;

	localparam int VALUE_W = 32;
	localparam int POS_W   = 8;
	localparam int CFG_W   = 7;

	// controller -> datapath
	typedef struct packed {
		logic load;        // input transfer, store element
		logic setup;       // latch effective k, clear pass state
		logic start_scan;  // restart address sweep
		logic run;         // sweep active
		logic emit;        // sweep is the emission pass
		logic clear_count; // vector finished
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic k_zero;
		logic scan_done;
		logic last_pass;
	} status_t;

endpackage

@@ rtl/tkis_if.sv @@
// ---------------------------------------------------------------------------
// tkis_if
// Channel interfaces: element input, position output, k write port.
// ---------------------------------------------------------------------------
interface tkis_in_if import tkis_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [VALUE_W-1:0]  sample_value;
	logic                       final_item;

	modport source (output valid, sample_value, final_item, input ready);
	modport sink   (input valid, sample_value, final_item, output ready);
endinterface

interface tkis_out_if import tkis_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [POS_W-1:0]   chosen_position;
	logic               last_chosen;

	modport source (output valid, chosen_position, last_chosen, input ready);
	modport sink   (input valid, chosen_position, last_chosen, output ready);
endinterface

interface tkis_cfg_if import tkis_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CFG_W-1:0]   select_count;

	modport source (output valid, select_count, input ready);
	modport sink   (input valid, select_count, output ready);
endinterface

@@ rtl/tkis_ctrl.sv @@
// ---------------------------------------------------------------------------
// tkis_ctrl
// Sequencer: load, setup, k ranking passes, emission pass.
// ---------------------------------------------------------------------------
module tkis_ctrl import tkis_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_final,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	localparam logic [1:0] ST_LOAD  = 2'd0;
	localparam logic [1:0] ST_SETUP = 2'd1;
	localparam logic [1:0] ST_RANK  = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready = (state_q == ST_LOAD);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_LOAD: begin
				cmd.load = in_valid;
				if (in_valid && in_final) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				if (status.k_zero) begin
					cmd.clear_count = 1'b1;
					state_d         = ST_LOAD;
				end else begin
					cmd.start_scan = 1'b1;
					state_d        = ST_RANK;
				end
			end
			ST_RANK: begin
				cmd.run = 1'b1;
				if (status.scan_done) begin
					cmd.start_scan = 1'b1;
					if (status.last_pass) begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_EMIT: begin
				cmd.run  = 1'b1;
				cmd.emit = 1'b1;
				if (status.scan_done) begin
					cmd.clear_count = 1'b1;
					state_d         = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/tkis_datapath.sv @@
// ---------------------------------------------------------------------------
// tkis_datapath
// Element store, sweep address, threshold search and output register.
// ---------------------------------------------------------------------------
module tkis_datapath import tkis_pkg::*; #(
	parameter int MAX_ELEMENTS = 256,
	parameter int MAX_SELECT   = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	output status_t                   status,
	input  logic signed [VALUE_W-1:0] sample_value,
	input  logic                      cfg_wr,
	input  logic [CFG_W-1:0]          cfg_data,
	input  logic                      out_ready,
	output logic                      out_valid,
	output logic [POS_W-1:0]          out_pos,
	output logic                      out_last
);

	localparam int AW = $clog2(MAX_ELEMENTS);
	localparam int CW = $clog2(MAX_ELEMENTS + 1);
	localparam int SW = $clog2(MAX_SELECT + 1);

	logic signed [VALUE_W-1:0] mem [MAX_ELEMENTS];

	logic [CFG_W-1:0] select_count_q;
	logic [CW-1:0]    load_count_q;
	logic [SW-1:0]    k_q;
	logic [SW-1:0]    pass_cnt_q;
	logic [SW-1:0]    emit_cnt_q;

	logic [AW-1:0]    addr_q;
	logic             iss_q;
	logic             vld_s1;
	logic [AW-1:0]    pos_s1;
	logic signed [VALUE_W-1:0] val_s1;

	logic                      thr_valid_q;
	logic signed [VALUE_W-1:0] thr_val_q;
	logic [AW-1:0]             thr_pos_q;
	logic                      best_valid_q;
	logic signed [VALUE_W-1:0] best_val_q;
	logic [AW-1:0]             best_pos_q;

	logic [31:0]   sel_w, cap_sel, cap_cnt;
	logic [SW-1:0] k_comb;
	logic          store_room;
	logic          last_addr;
	logic          thr_beats_e, e_beats_best;
	logic          eligible, take, qual;
	logic          stall, rd_en, out_load;
	logic [AW+POS_W-1:0] pos_ext;

	// effective k: saturate to MAX_SELECT and to the loaded count
	assign sel_w   = 32'(select_count_q);
	assign cap_sel = (sel_w > 32'(MAX_SELECT)) ? 32'(MAX_SELECT) : sel_w;
	assign cap_cnt = (cap_sel > 32'(load_count_q)) ? 32'(load_count_q) : cap_sel;
	assign k_comb  = cap_cnt[SW-1:0];

	assign store_room = (load_count_q != CW'(MAX_ELEMENTS));
	assign last_addr  = (CW'(addr_q) == load_count_q - CW'(1));

	// total order: larger value first, lower position on a tie
	assign thr_beats_e  = (thr_val_q > val_s1) ||
	                      ((thr_val_q == val_s1) && (thr_pos_q < pos_s1));
	assign e_beats_best = (val_s1 > best_val_q) ||
	                      ((val_s1 == best_val_q) && (pos_s1 < best_pos_q));
	assign eligible     = !thr_valid_q || thr_beats_e;
	assign take         = eligible && (!best_valid_q || e_beats_best);
	assign qual         = !eligible;

	assign stall    = cmd.emit && vld_s1 && qual && out_valid && !out_ready;
	assign rd_en    = cmd.run && iss_q && !stall;
	assign out_load = cmd.emit && vld_s1 && qual && !stall;

	assign status.k_zero    = (k_comb == '0);
	assign status.scan_done = cmd.run && vld_s1 && !stall &&
	                          (CW'(pos_s1) == load_count_q - CW'(1));
	assign status.last_pass = (pass_cnt_q == k_q - SW'(1));

	assign pos_ext = {{POS_W{1'b0}}, pos_s1};

	// element store
	always_ff @(posedge clk) begin
		if (cmd.load && store_room) begin
			mem[load_count_q[AW-1:0]] <= sample_value;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			val_s1 <= mem[addr_q];
			pos_s1 <= addr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			select_count_q <= CFG_W'(1);
			load_count_q   <= '0;
			k_q            <= '0;
			pass_cnt_q     <= '0;
			emit_cnt_q     <= '0;
			addr_q         <= '0;
			iss_q          <= 1'b0;
			vld_s1         <= 1'b0;
			thr_valid_q    <= 1'b0;
			best_valid_q   <= 1'b0;
			out_valid      <= 1'b0;
		end else begin
			if (cfg_wr) begin
				select_count_q <= cfg_data;
			end

			if (cmd.clear_count) begin
				load_count_q <= '0;
			end else if (cmd.load && store_room) begin
				load_count_q <= load_count_q + CW'(1);
			end

			if (cmd.setup) begin
				k_q         <= k_comb;
				pass_cnt_q  <= '0;
				emit_cnt_q  <= '0;
				thr_valid_q <= 1'b0;
			end else if (status.scan_done && !cmd.emit) begin
				thr_valid_q <= 1'b1;
				pass_cnt_q  <= pass_cnt_q + SW'(1);
			end

			if (cmd.start_scan) begin
				addr_q       <= '0;
				iss_q        <= 1'b1;
				vld_s1       <= 1'b0;
				best_valid_q <= 1'b0;
			end else begin
				if (rd_en) begin
					addr_q <= addr_q + AW'(1);
					if (last_addr) begin
						iss_q <= 1'b0;
					end
				end
				if (cmd.run && !stall) begin
					vld_s1 <= iss_q;
				end
				if (cmd.run && !cmd.emit && vld_s1 && take) begin
					best_valid_q <= 1'b1;
				end
			end

			if (out_load) begin
				out_valid  <= 1'b1;
				emit_cnt_q <= emit_cnt_q + SW'(1);
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.run && !cmd.emit && vld_s1 && take) begin
			best_val_q <= val_s1;
			best_pos_q <= pos_s1;
		end
		if (status.scan_done && !cmd.emit) begin
			if (take) begin
				thr_val_q <= val_s1;
				thr_pos_q <= pos_s1;
			end else begin
				thr_val_q <= best_val_q;
				thr_pos_q <= best_pos_q;
			end
		end
		if (out_load) begin
			out_pos  <= pos_ext[POS_W-1:0];
			out_last <= (emit_cnt_q == k_q - SW'(1));
		end
	end

endmodule

@@ rtl/top_k_index_select.sv @@
// ---------------------------------------------------------------------------
// top_k_index_select
// Reports the positions of the k largest Q16.16 elements of a vector.
// ---------------------------------------------------------------------------
//
//  channel   dir  payload                               transfer when
//  in_ch     in   sample_value[31:0] s, final_item      valid & ready
//  out_ch    out  chosen_position[7:0], last_chosen     valid & ready
//  cfg_ch    in   select_count[6:0]                     valid & ready (ready always 1)
//
//  Loading: one element per cycle, ready high whenever the block is loading.
//  After the final element: a setup step, then k ranking sweeps and one
//  emission sweep over the n stored elements, each through the single
//  registered read port of the store; a stalled output holds the emission
//  sweep. k of zero: straight back to loading, nothing emitted.
//  Reset clears control only; the store needs no clearing pass.
//  A result waiting in the output register does not block loading.
//
`include "top_k_index_select_defines.svh"

module top_k_index_select import tkis_pkg::*; #(
	parameter int MAX_ELEMENTS = 256,
	parameter int MAX_SELECT   = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	tkis_in_if.sink    in_ch,
	tkis_out_if.source out_ch,
	tkis_cfg_if.sink   cfg_ch
);

	cmd_t    cmd;
	status_t status;

	// k register is a plain flop, always writable
	assign cfg_ch.ready = 1'b1;

	// Sequencer. Each ranking sweep finds the next element in rank order
	// below the current threshold; after k sweeps the threshold is the k-th
	// largest, and the emission sweep sends every position at or above it.
	tkis_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_final (in_ch.final_item),
		.in_ready (in_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	tkis_datapath #(
		.MAX_ELEMENTS (MAX_ELEMENTS),
		.MAX_SELECT   (MAX_SELECT)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.sample_value (in_ch.sample_value),
		.cfg_wr       (cfg_ch.valid),
		.cfg_data     (cfg_ch.select_count),
		.out_ready    (out_ch.ready),
		.out_valid    (out_ch.valid),
		.out_pos      (out_ch.chosen_position),
		.out_last     (out_ch.last_chosen)
	);

	// no element transfer while a sweep is running
	`TKIS_ASSERT_IMPLY(a_no_load_in_sweep, clk, arst_n, in_ch.valid && in_ch.ready, !cmd.run, "element transfer during sweep")

	// final element always leads to the setup cycle
	`TKIS_ASSERT_NEXT(a_final_to_setup, clk, arst_n, in_ch.valid && in_ch.ready && in_ch.final_item, cmd.setup, "final element did not start selection")

	// k of zero returns straight to loading
	`TKIS_ASSERT_NEXT(a_k_zero_idle, clk, arst_n, cmd.setup && status.k_zero, in_ch.ready && !cmd.run, "empty selection did not return to loading")

	// sweep completion is only reported while sweeping
	`TKIS_ASSERT_IMPLY(a_done_in_sweep, clk, arst_n, status.scan_done, cmd.run, "sweep done outside a sweep")

endmodule

@@ verif/tkis_position_checker.sv @@
// ---------------------------------------------------------------------------
// tkis_position_checker
// Mirrors the element store, predicts the top-k positions of each vector and
// compares every output transfer against them in order.
// ---------------------------------------------------------------------------
module tkis_position_checker import tkis_pkg::*; #(
	parameter int MAX_ELEMENTS = 256,
	parameter int MAX_SELECT   = 64
) (
	input  logic clk,
	input  logic arst_n,
	tkis_in_if   in_ch,
	tkis_out_if  out_ch,
	tkis_cfg_if  cfg_ch,
	output int   mismatches,
	output int   owed
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic             last;
	} pick_t;

	logic signed [VALUE_W-1:0] elem_mirror [MAX_ELEMENTS];
	int                        loaded;
	logic [CFG_W-1:0]          k_reg;
	pick_t                     due_positions [$];
	int                        miss_total;

	// larger value wins, lower position breaks ties
	function automatic bit outranks_at(int a, int b);
		if (elem_mirror[a] != elem_mirror[b])
			return elem_mirror[a] > elem_mirror[b];
		return a < b;
	endfunction

	function automatic void queue_top_positions();
		int    k_eff;
		int    rank;
		int    taken;
		pick_t p;
		k_eff = int'(k_reg);
		if (k_eff > MAX_SELECT)
			k_eff = MAX_SELECT;
		if (k_eff > loaded)
			k_eff = loaded;
		taken = 0;
		for (int i = 0; i < loaded && taken < k_eff; i++) begin
			rank = 0;
			for (int j = 0; j < loaded; j++)
				if (j != i && outranks_at(j, i))
					rank++;
			if (rank < k_eff) begin
				p.pos  = POS_W'(i);
				p.last = (taken == k_eff - 1);
				due_positions.push_back(p);
				taken++;
			end
		end
		loaded = 0;
	endfunction

	function automatic void note_miss(string msg);
		miss_total++;
		if (miss_total <= 10)
			$display("%s", msg);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pick_t got;
		pick_t want;
		if (!arst_n) begin
			loaded     = 0;
			k_reg      = CFG_W'(1);
			miss_total = 0;
			due_positions.delete();
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				got.pos  = out_ch.chosen_position;
				got.last = out_ch.last_chosen;
				if (due_positions.size() == 0) begin
					note_miss($sformatf("unexpected result: pos %0d last %0b",
						got.pos, got.last));
				end else begin
					want = due_positions.pop_front();
					if (got.pos !== want.pos || got.last !== want.last)
						note_miss($sformatf("result mismatch: expected pos %0d last %0b, got pos %0d last %0b",
							want.pos, want.last, got.pos, got.last));
				end
			end
			if (cfg_ch.valid && cfg_ch.ready)
				k_reg = cfg_ch.select_count;
			if (in_ch.valid && in_ch.ready) begin
				// store full: element dropped, a final one still triggers selection
				if (loaded < MAX_ELEMENTS) begin
					elem_mirror[loaded] = in_ch.sample_value;
					loaded++;
				end
				if (in_ch.final_item)
					queue_top_positions();
			end
		end
		mismatches <= miss_total;
		owed       <= due_positions.size();
	end

endmodule

@@ verif/tb_top_k_index_select.sv @@
// ---------------------------------------------------------------------------
// tb_top_k_index_select
// Drives vectors and k settings into the top-k index select block, with
// random idling on both channels and one long output hold-off; the checker
// beside the block predicts and compares every position transfer.
// ---------------------------------------------------------------------------
module tb_top_k_index_select;
	timeunit 1ns;
	timeprecision 1ps;
	import tkis_pkg::*;

	localparam int MAX_ELEMENTS   = 256;
	localparam int MAX_SELECT     = 64;
	localparam int RANDOM_ITEMS   = 30;
	localparam int CALM_ITEMS     = 10;              // tail of the run without idling
	localparam int SETTLE_CYCLES  = MAX_ELEMENTS + 16; // an emission sweep may outlast its last result
	localparam int SQUEEZE_CYCLES = 400;
	localparam int CYCLE_LIMIT    = 500_000;

	localparam logic [CFG_W-1:0] K_NONE = CFG_W'(0);
	localparam logic [CFG_W-1:0] K_ONE  = CFG_W'(1);
	localparam logic [CFG_W-1:0] K_MAX  = CFG_W'(MAX_SELECT);
	localparam logic [CFG_W-1:0] K_TOP  = {CFG_W{1'b1}};   // above MAX_SELECT, saturates

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	int   mismatches;
	int   owed;
	int   cycles = 0;
	bit   calm = 1'b0;         // no idling on either side once set
	bit   squeeze_req = 1'b0;  // asks the receiver for its long hold-off
	bit   squeeze_done = 1'b0;

	tkis_in_if  in_ch ();
	tkis_out_if out_ch ();
	tkis_cfg_if cfg_ch ();

	top_k_index_select #(
		.MAX_ELEMENTS(MAX_ELEMENTS),
		.MAX_SELECT  (MAX_SELECT)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.out_ch(out_ch),
		.cfg_ch(cfg_ch)
	);

	tkis_position_checker #(
		.MAX_ELEMENTS(MAX_ELEMENTS),
		.MAX_SELECT  (MAX_SELECT)
	) checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_ch    (cfg_ch),
		.mismatches(mismatches),
		.owed      (owed)
	);

	// 2 ns clock
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Run guard: a hung block or a lost result ends up here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Element value mix: near-zero ties, rail values, whole Q16.16 numbers
	// with frequent ties, and fully random words.
	function automatic logic signed [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 4))
			0: return VALUE_W'(int'($urandom_range(0, 6)) - 3);
			1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			2: return {16'($urandom_range(0, 7)) - 16'd4, 16'h0000};
			default: return $urandom;
		endcase
	endfunction

	// One element transfer. Entered and left just after a rising edge; an
	// idle burst lowers valid first so no step sees two updates of it.
	task automatic put_elem(input logic signed [VALUE_W-1:0] v, input logic fin);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.sample_value <= v;
		in_ch.final_item   <= fin;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic send_vector(input int len);
		for (int i = 0; i < len; i++)
			put_elem(pick_value(), i == len - 1);
	endtask

	// Block idle: input closed, every predicted position seen, and the
	// trailing sweep given time to finish (owed is a registered copy, hence
	// the first wait).
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (owed != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_k(input logic [CFG_W-1:0] k);
		cfg_ch.valid        <= 1'b1;
		cfg_ch.select_count <= k;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	// Receiver: random ready bursts, one long hold-off on request, none in
	// the calm tail. Exactly one update of ready per step.
	initial begin
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (squeeze_req && !squeeze_done) begin
				out_ch.ready <= 1'b0;
				repeat (SQUEEZE_CYCLES) @(posedge clk);
				squeeze_done = 1'b1;
				out_ch.ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				out_ch.ready <= 1'b1;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Stimulus and verdict
	initial begin
		int               rand_items;
		int               phase;
		int               vectors;
		int               vec_len;
		logic [CFG_W-1:0] k_pick;

		in_ch.valid         = 1'b0;
		in_ch.sample_value  = '0;
		in_ch.final_item    = 1'b0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.select_count = '0;
		rand_items          = 0;
		phase               = 0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part ---
		// reset k of one: both rails and zero, the top rail wins
		put_elem(32'h8000_0000, 1'b0);
		put_elem(32'h7FFF_FFFF, 1'b0);
		put_elem(32'h0000_0000, 1'b1);
		// single-element vector
		put_elem(32'h8000_0000, 1'b1);
		wait_idle();

		// k zero: vector discarded, nothing emitted
		write_k(K_NONE);
		put_elem(32'sd5, 1'b0);
		put_elem(-32'sd5, 1'b1);
		wait_idle();

		// all equal: lowest positions win the ties
		write_k(CFG_W'(3));
		repeat (4) put_elem(32'sd7, 1'b0);
		put_elem(32'sd7, 1'b1);
		// negatives with a tie inside the top k
		put_elem(-32'sd1, 1'b0);
		put_elem(-32'sd3, 1'b0);
		put_elem(32'h8000_0000, 1'b0);
		put_elem(-32'sd2, 1'b0);
		put_elem(-32'sd1, 1'b1);
		wait_idle();

		// k beyond both the vector length and MAX_SELECT
		write_k(K_TOP);
		put_elem(32'sd1, 1'b0);
		put_elem(32'sd2, 1'b0);
		put_elem(32'sd3, 1'b0);
		put_elem(32'sd4, 1'b1);
		wait_idle();

		// output order is by position, not by value
		write_k(CFG_W'(2));
		put_elem(32'hFFFF_FFFF, 1'b0);
		put_elem(32'h0000_0001, 1'b0);
		put_elem(32'h7FFF_FFFF, 1'b0);
		put_elem(32'h8000_0000, 1'b1);
		wait_idle();

		// store full: the last two elements, the final one among them, are
		// dropped; k saturates to MAX_SELECT
		write_k(K_TOP);
		send_vector(MAX_ELEMENTS + 2);
		wait_idle();

		// --- random part ---
		while (rand_items < RANDOM_ITEMS) begin
			if (phase == 0) begin
				// several vectors back to back against a long output hold-off,
				// so the output fills and the input stalls
				squeeze_req = 1'b1;
				k_pick      = CFG_W'(5);
				vectors     = 4;
			end else begin
				case ($urandom_range(0, 7))
					0: k_pick = K_NONE;
					1: k_pick = K_ONE;
					2: k_pick = K_MAX;
					3: k_pick = K_TOP;
					4, 5: k_pick = CFG_W'($urandom_range(2, 8));
					default: k_pick = CFG_W'($urandom);
				endcase
				vectors = $urandom_range(2, 5);
			end
			write_k(k_pick);
			repeat (vectors) begin
				// mostly short vectors, now and then a longer one
				vec_len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 80)
					: $urandom_range(1, 12);
				for (int i = 0; i < vec_len; i++) begin
					calm = (rand_items >= RANDOM_ITEMS - CALM_ITEMS);
					put_elem(pick_value(), i == vec_len - 1);
					rand_items++;
				end
			end
			wait_idle();
			phase++;
		end

		if (mismatches == 0 && owed == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
